// File: hw/rtl/aes_ctr_block_cipher_core_assert.svh
// Assertion macros shared by the AES counter-mode core.
`ifndef AES_CTR_BLOCK_CIPHER_CORE_ASSERT_SVH
`define AES_CTR_BLOCK_CIPHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ACC_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) \
  prop) else $error("aes ctr core check failed");
`define ACC_NEVER(lbl, cond) `ACC_ASSERT(lbl, !(cond))
`else
`define ACC_ASSERT(lbl, prop)
`define ACC_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/aesctr_pkg.sv
// Types, tables and helper functions for the AES counter-mode core.
package aesctr_pkg;

  localparam logic [3:0] ROUNDS_128 = 4'd10;
  localparam logic [3:0] ROUNDS_256 = 4'd14;

  typedef enum logic [2:0] {
    REG_KEY_MODE  = 3'd0,
    REG_KEY_WORD0 = 3'd1,
    REG_KEY_WORD1 = 3'd2,
    REG_KEY_WORD2 = 3'd3,
    REG_KEY_WORD3 = 3'd4,
    REG_CTR_HIGH  = 3'd5,
    REG_CTR_LOW   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic        first_block;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  valid_bytes;
  } out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

endpackage

// File: hw/rtl/aesctr_round.sv
// One AES round: substitute, shift rows, optional column mix, round key add.
module aesctr_round (
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         last,
  output logic [127:0] state_out
);

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mc [16];

  // Substitute every byte, then rotate rows
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = aesctr_pkg::sub_byte(state_in[127 - 8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[i + 4*c] = sb[i + 4*((c + i) % 4)];
      end
    end
  end

  // Mix columns except in the final round
  always_comb begin
    logic [7:0] all;
    for (int c = 0; c < 4; c++) begin
      all = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      for (int i = 0; i < 4; i++) begin
        if (last) begin
          mc[4*c+i] = sr[4*c+i];
        end else begin
          mc[4*c+i] = sr[4*c+i] ^ all ^ xtime(sr[4*c+i] ^ sr[4*c + ((i+1) % 4)]);
        end
      end
    end
  end

  // Add the round key
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      state_out[127 - 8*i -: 8] = mc[i] ^ round_key[127 - 8*i -: 8];
    end
  end

endmodule

// File: hw/rtl/aesctr_keysched.sv
// Key schedule window: produces one round key per cycle while advance is high, on the fly.
module aesctr_keysched (
  input  logic         clk,
  input  logic         load,
  input  logic         advance,
  input  logic         key_mode,
  input  logic [255:0] key,
  input  logic [3:0]   rnd,
  output logic [127:0] round_key
);

  logic [255:0] win;

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Window holds round r key in its upper half; step it to round r+1
  function automatic logic [255:0] step(input logic [255:0] w, input logic m,
                                        input logic [3:0] r);
    logic [127:0] a;
    logic [127:0] b;
    logic [31:0]  prev;
    logic [31:0]  t;
    logic [3:0]   idx;
    logic [31:0]  n0, n1, n2, n3;
    a    = w[255:128];
    b    = w[127:0];
    prev = m ? b[31:0] : a[31:0];
    idx  = m ? ({1'b0, r[3:1]} + 4'd1) : (r + 4'd1);
    if (!m || !r[0]) begin
      t = aesctr_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon(idx), 24'h0};
    end else begin
      t = aesctr_pkg::sub_word(prev);
    end
    n0 = a[127:96] ^ t;
    n1 = a[95:64] ^ n0;
    n2 = a[63:32] ^ n1;
    n3 = a[31:0] ^ n2;
    return m ? {b, n0, n1, n2, n3} : {n0, n1, n2, n3, b};
  endfunction

  // Load the round 1 window at accept, advance once per round
  always_ff @(posedge clk) begin
    if (load) begin
      win <= step(key, key_mode, 4'd0);
    end else if (advance) begin
      win <= step(win, key_mode, rnd);
    end
  end

  assign round_key = win[255:128];

endmodule

// File: hw/rtl/aes_ctr_block_cipher_core.sv
// Top level of the AES counter-mode core: registers, sequencer and output stage.
//
//   channel  | signals                    | direction | payload
//   in       | in_valid / in_ready        | to core   | aesctr_pkg::in_t
//   out      | out_valid / out_ready      | from core | aesctr_pkg::out_t
//   config   | cfg_write, cfg_index       | to core   | cfg_data, 64 bits
//
// A request is loaded at accept, then runs each AES round through the shared round
// unit (10 rounds with a 128-bit key, 14 with a 256-bit key), then writes the output
// register. Round keys are derived on the fly, one per cycle.
// Reset clears configuration, counter and handshake state. A stalled output holds the
// core in FIN before the final write; no new request is taken until that write is done.
module aes_ctr_block_cipher_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aesctr_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aesctr_pkg::out_t  out_data,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
`include "aes_ctr_block_cipher_core_assert.svh"

  typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;

  state_t       state;
  logic [3:0]   rnd;
  logic         key_mode;
  logic [63:0]  key_word0, key_word1, key_word2, key_word3;
  logic [63:0]  ctr_start_high, ctr_start_low;
  logic [127:0] counter;
  logic [127:0] blk;
  logic [127:0] data;
  logic [4:0]   count;

  logic         accept;
  logic [127:0] ctr_used;
  logic [255:0] key;
  logic [127:0] round_key;
  logic [127:0] round_out;
  logic [3:0]   last_rnd;
  logic [4:0]   count_next;
  logic [127:0] mask;
  logic         out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == IDLE);
  assign key      = {key_word0, key_word1, key_word2, key_word3};
  assign ctr_used = in_data.first_block ? {ctr_start_high, ctr_start_low} : counter;
  assign last_rnd = key_mode ? aesctr_pkg::ROUNDS_256 : aesctr_pkg::ROUNDS_128;
  assign count_next = (in_data.byte_count > 5'd16) ? 5'd16 : in_data.byte_count;
  assign out_free = !out_valid || out_ready;

  // Keep leading bytes below the count
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      mask[127 - 8*j -: 8] = ({1'b0, 4'(j)} < count) ? 8'hff : 8'h00;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode       <= 1'b0;
      key_word0      <= '0;
      key_word1      <= '0;
      key_word2      <= '0;
      key_word3      <= '0;
      ctr_start_high <= '0;
      ctr_start_low  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        aesctr_pkg::REG_KEY_MODE:  key_mode       <= cfg_data[0];
        aesctr_pkg::REG_KEY_WORD0: key_word0      <= cfg_data;
        aesctr_pkg::REG_KEY_WORD1: key_word1      <= cfg_data;
        aesctr_pkg::REG_KEY_WORD2: key_word2      <= cfg_data;
        aesctr_pkg::REG_KEY_WORD3: key_word3      <= cfg_data;
        aesctr_pkg::REG_CTR_HIGH:  ctr_start_high <= cfg_data;
        aesctr_pkg::REG_CTR_LOW:   ctr_start_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  aesctr_keysched u_keysched (
    .clk       (clk),
    .load      (accept),
    .advance   (state == RUN),
    .key_mode  (key_mode),
    .key       (key),
    .rnd       (rnd),
    .round_key (round_key)
  );

  aesctr_round u_round (
    .state_in  (blk),
    .round_key (round_key),
    .last      (rnd == last_rnd),
    .state_out (round_out)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      blk   <= ctr_used ^ key[255:128];
      data  <= {in_data.data_high, in_data.data_low};
      count <= count_next;
    end else if (state == RUN) begin
      blk <= round_out;
    end
    if (state == FIN && out_free) begin
      out_data <= {(data ^ blk) & mask, count};
    end
  end

  // Sequencer, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rnd       <= '0;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            counter <= ctr_used + 128'd1;
            rnd     <= 4'd1;
            state   <= RUN;
          end
        end
        RUN: begin
          if (rnd == last_rnd) begin
            state <= FIN;
          end else begin
            rnd <= rnd + 4'd1;
          end
        end
        FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ACC_ASSERT(a_rnd_range, rnd <= aesctr_pkg::ROUNDS_256)
  `ACC_ASSERT(a_accept_runs, accept |=> (state == RUN))
  `ACC_ASSERT(a_rnd_128, (state == RUN && !key_mode) |-> (rnd <= aesctr_pkg::ROUNDS_128))
  `ACC_ASSERT(a_fin_fills, (state == FIN && out_free) |=> (out_valid && state == IDLE))
  `ACC_NEVER(a_rnd_zero, state == RUN && rnd == 4'd0)

endmodule

// File: verif/aes_ctr_block_cipher_core_tb.sv
// Self-checking testbench for the AES counter-mode core, with its own cipher and counter model.
module aes_ctr_block_cipher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT = 4000;
  localparam logic [7:0] RCON [11] = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                       8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  aesctr_pkg::in_t   in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  aesctr_pkg::out_t  out_data;
  logic              cfg_write = 1'b0;
  logic [2:0]        cfg_index = aesctr_pkg::REG_KEY_MODE;
  logic [63:0]       cfg_data = '0;

  // Shadow of the core's registers and counter
  logic          aes256_sel;
  logic [63:0]   key_words [4];
  logic [127:0]  ctr_start;
  logic [127:0]  ctr_now;
  logic [127:0]  round_keys [15];

  aesctr_pkg::in_t  block_q [$];
  aesctr_pkg::out_t ciphertext_q [$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   calm = 1'b0;

  aes_ctr_block_cipher_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Rebuild the round keys from the shadow key registers
  function automatic void expand_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    int nk;
    int total;
    nk = aes256_sel ? 8 : 4;
    total = aes256_sel ? 60 : 44;
    for (int i = 0; i < 60; i++) w[i] = '0;
    for (int i = 0; i < 4; i++) begin
      w[2*i] = key_words[i][63:32];
      w[2*i+1] = key_words[i][31:0];
    end
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = aesctr_pkg::sub_word(t);
        t[31:24] ^= RCON[(i / nk) % 11];
      end else if (nk == 8 && i % nk == 4) begin
        t = aesctr_pkg::sub_word(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r < 15; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  // Encrypt one counter block, byte 0 in the top bits
  function automatic logic [127:0] encipher(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    int rounds;
    rounds = aes256_sel ? 14 : 10;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ round_keys[0][127-8*i -: 8];
    for (int r = 1; r <= rounds; r++) begin
      for (int i = 0; i < 16; i++) s[i] = aesctr_pkg::SBOX[s[i]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = s[i+4*((c+i)&3)];
      s = t;
      if (r != rounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
          s[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          s[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          s[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
    return blk;
  endfunction

  // Work out the ciphertext of one request and advance the counter
  function automatic aesctr_pkg::out_t ctr_encrypt(input aesctr_pkg::in_t req);
    aesctr_pkg::out_t res;
    logic [127:0] stream;
    logic [127:0] keep;
    int n;
    n = (req.byte_count > 5'd16) ? 16 : int'(req.byte_count);
    if (req.first_block) ctr_now = ctr_start;
    stream = encipher(ctr_now) ^ {req.data_high, req.data_low};
    keep = '0;
    for (int i = 0; i < n; i++) keep[127-8*i -: 8] = 8'hff;
    stream &= keep;
    res.result_high = stream[127:64];
    res.result_low = stream[63:0];
    res.valid_bytes = 5'(n);
    ctr_now = ctr_now + 128'd1;
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Write one register and mirror it in the shadow
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      aesctr_pkg::REG_KEY_MODE:  aes256_sel = val[0];
      aesctr_pkg::REG_KEY_WORD0: key_words[0] = val;
      aesctr_pkg::REG_KEY_WORD1: key_words[1] = val;
      aesctr_pkg::REG_KEY_WORD2: key_words[2] = val;
      aesctr_pkg::REG_KEY_WORD3: key_words[3] = val;
      aesctr_pkg::REG_CTR_HIGH:  ctr_start[127:64] = val;
      aesctr_pkg::REG_CTR_LOW:   ctr_start[63:0] = val;
      default: ;
    endcase
    expand_keys();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic aesctr_pkg::in_t make_block(input logic [4:0] cnt, input logic first);
    aesctr_pkg::in_t b;
    b.data_high = {$urandom, $urandom};
    b.data_low = {$urandom, $urandom};
    b.byte_count = cnt;
    b.first_block = first;
    return b;
  endfunction

  // Queue well-formed messages, with some odd requests mixed in
  task automatic queue_messages(input int target);
    int queued;
    int len;
    queued = 0;
    while (queued < target) begin
      if ($urandom_range(9) == 0) begin
        block_q.push_back(make_block(5'($urandom_range(31)), 1'($urandom)));
        queued++;
      end else begin
        len = $urandom_range(6);
        block_q.push_back(make_block(5'd16, 1'b1));
        for (int i = 0; i < len; i++) block_q.push_back(make_block(5'd16, 1'b0));
        if ($urandom_range(1)) block_q.push_back(make_block(5'($urandom_range(15, 1)), 1'b0));
        queued += len + 2;
      end
    end
  endtask

  // Let every request drain, then let the core settle
  task automatic drain();
    while (block_q.size() != 0 || in_valid || ciphertext_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive requests from the queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) ciphertext_q.push_back(ctr_encrypt(in_data));
      if (!in_valid || in_ready) begin
        if (block_q.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
          in_valid <= 1'b1;
          in_data <= block_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept results and check them against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 11;
      if (out_valid && out_ready) begin
        if (ciphertext_q.size() == 0) begin
          report("unexpected result", out_data.result_high, '0);
        end else begin
          if (out_data.result_high !== ciphertext_q[0].result_high)
            report("result_high", out_data.result_high, ciphertext_q[0].result_high);
          if (out_data.result_low !== ciphertext_q[0].result_low)
            report("result_low", out_data.result_low, ciphertext_q[0].result_low);
          if (out_data.valid_bytes !== ciphertext_q[0].valid_bytes)
            report("valid_bytes", 64'(out_data.valid_bytes), 64'(ciphertext_q[0].valid_bytes));
          void'(ciphertext_q.pop_front());
        end
      end
    end
  end

  // Hold a limit on cycles with no handshake and no register write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    aes256_sel = 1'b0;
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    ctr_start = '0;
    ctr_now = '0;
    expand_keys();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: size extremes, continuation after a partial block
    block_q.push_back('{64'h0, 64'h0, 5'd16, 1'b0});
    block_q.push_back('{'1, '1, 5'd16, 1'b0});
    block_q.push_back('{'1, '1, 5'd0, 1'b0});
    block_q.push_back('{'1, '1, 5'd1, 1'b1});
    block_q.push_back('{'1, '1, 5'd7, 1'b0});
    block_q.push_back('{'1, '1, 5'd8, 1'b0});
    block_q.push_back('{'1, '1, 5'd9, 1'b0});
    block_q.push_back('{'1, '1, 5'd15, 1'b0});
    block_q.push_back('{'1, '1, 5'd17, 1'b0});
    block_q.push_back('{'1, '1, 5'd31, 1'b1});
    block_q.push_back(make_block(5'd16, 1'b0));
    drain();

    // AES-128 with the counter about to wrap
    write_reg(aesctr_pkg::REG_KEY_WORD0, {$urandom, $urandom});
    write_reg(aesctr_pkg::REG_KEY_WORD1, {$urandom, $urandom});
    write_reg(aesctr_pkg::REG_CTR_HIGH, '1);
    write_reg(aesctr_pkg::REG_CTR_LOW, 64'hffff_ffff_ffff_fffe);
    for (int i = 0; i < 4; i++) block_q.push_back(make_block(5'd16, i == 0));
    block_q.push_back(make_block(5'd5, 1'b0));
    queue_messages(100);
    drain();

    // AES-256, random keys, no idling on either side
    calm = 1'b1;
    write_reg(aesctr_pkg::REG_KEY_MODE, 64'd1);
    write_reg(aesctr_pkg::REG_KEY_WORD2, {$urandom, $urandom});
    write_reg(aesctr_pkg::REG_KEY_WORD3, {$urandom, $urandom});
    write_reg(aesctr_pkg::REG_CTR_HIGH, {$urandom, $urandom});
    write_reg(aesctr_pkg::REG_CTR_LOW, '1);
    queue_messages(150);
    drain();
    calm = 1'b0;

    // AES-256 with an all-ones key
    for (int i = 0; i < 4; i++) write_reg(3'(aesctr_pkg::REG_KEY_WORD0 + i), '1);
    write_reg(aesctr_pkg::REG_CTR_HIGH, '0);
    write_reg(aesctr_pkg::REG_CTR_LOW, '0);
    queue_messages(140);
    drain();

    // Back to AES-128: lower key words must not matter, stray index ignored
    write_reg(aesctr_pkg::REG_KEY_MODE, '0);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(aesctr_pkg::REG_KEY_WORD2, {$urandom, $urandom});
    write_reg(aesctr_pkg::REG_CTR_LOW, {$urandom, $urandom});
    queue_messages(140);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
